/* hw/rtl/rcce_pkg.sv */
// package for the ram cartridge command engine: codes, states and constants
`timescale 1ns / 1ps

package rcce_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int PASSWORD_LEN = 8;
  localparam int MAX_TRIES = 3;

  localparam logic [6:0] IMAGE_KB_RESET = 7'd64;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // host request kinds
  localparam logic [1:0] REQ_CMD = 2'd0;
  localparam logic [1:0] REQ_DATA = 2'd1;
  localparam logic [1:0] REQ_SLOT = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  // command codes
  localparam logic [7:0] CMD_STATUS = 8'h00;
  localparam logic [7:0] CMD_RD_DEC_A = 8'h10;
  localparam logic [7:0] CMD_RD_DEC_B = 8'h18;
  localparam logic [7:0] CMD_ERASE = 8'h20;
  localparam logic [7:0] CMD_LOCK = 8'h80;
  localparam logic [7:0] CMD_UNLOCK = 8'h90;
  localparam logic [7:0] CMD_SET_ADDR16 = 8'hA0;
  localparam logic [7:0] CMD_SET_ADDR24 = 8'hA8;
  localparam logic [7:0] CMD_GET_ADDR16 = 8'hB0;
  localparam logic [7:0] CMD_GET_ADDR24 = 8'hB8;
  localparam logic [7:0] CMD_WR_INC = 8'hC0;
  localparam logic [7:0] CMD_RD_INC_A = 8'hD0;
  localparam logic [7:0] CMD_RD_INC_B = 8'hD8;
  localparam logic [7:0] CMD_WR_DEC = 8'hE0;

  localparam logic [7:0] CMD_DIR_MASK = 8'hC0;
  localparam logic [15:0] ERASE_START = 16'hFFFF;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

/* hw/rtl/ram_cartridge_command_engine.sv */
// top level of the ram cartridge command engine
`timescale 1ns / 1ps

// Byte-level RAM cartridge engine. Each host request (command byte, data byte,
// read slot or select release) gives one result carrying the driven byte, the
// lock bit, the failed unlock count, the dirty flag and the address pointer.
// The accept cycle issues the synchronous byte store read at the current
// pointer; the execute state that follows uses the read data, writes the
// store back if needed and loads the output register. The execute state waits
// while an earlier result is still held at the output. After reset the block
// runs a clearing pass that fills all 2^ADDR_BITS store locations (65536 by
// default) with 0xFF; no item is accepted during it, configuration writes are.
module ram_cartridge_command_engine #(
  parameter int ADDR_BITS = rcce_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,    // image_size_kb
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  input  logic [1:0]  in_tuser,     // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] tx_byte, [8] is_locked, [10:9] failed_tries, [11] image_dirty,
  // [27:12] pointer_now, [31:28] zero
  output logic [31:0] out_tdata,
  output logic [0:0]  out_tuser     // [0] tx_valid
);
  import rcce_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  state_t state_r, state_nxt;

  logic [ADDR_BITS-1:0] clr_cnt_r;
  logic [6:0]           image_kb_r;

  logic [1:0]  req_r;
  logic [7:0]  byte_r;

  logic [7:0]  mem [DEPTH];
  logic [7:0]  mem_q_r;
  logic        mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [7:0]  mem_wdata;
  logic        store_wr;

  logic [15:0] ptr_r, ptr_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic        enabled_r, enabled_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        lock_r, lock_nxt;
  logic [1:0]  tries_r, tries_nxt;
  logic        dirty_r, dirty_nxt;
  logic [15:0] erase_cnt_r, erase_cnt_nxt;
  logic        mismatch_r, mismatch_nxt;

  logic        tx_valid_nxt;
  logic [7:0]  tx_byte_nxt;

  logic        out_valid_r;
  logic        tx_valid_r;
  logic [7:0]  tx_byte_r;
  logic        lock_out_r;
  logic [1:0]  tries_out_r;
  logic        dirty_out_r;
  logic [15:0] ptr_out_r;

  logic        in_fire;
  logic        exec_done;
  logic        in_range;
  logic [3:0]  phase_inc;
  logic [1:0]  addr_need;
  logic [7:0]  pw_char;
  logic        pw_miss;
  logic [15:0] erase_cnt_inc;

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == {ADDR_BITS{1'b1}}) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_EXEC;
      S_EXEC:  if (exec_done) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_tready = 1'b0;
    exec_done = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_EXEC:  exec_done = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      image_kb_r <= IMAGE_KB_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + ADDR_BITS'(1);
      if (cfg_we) image_kb_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  // byte store: reads only on accept, writes only while clearing or executing
  assign mem_we    = (state_r == S_CLEAR) || (exec_done && store_wr);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_cnt_r : ptr_r[ADDR_BITS-1:0];
  assign mem_wdata = (state_r == S_CLEAR) ? ERASED_BYTE : byte_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (in_fire) mem_q_r <= mem[ptr_r[ADDR_BITS-1:0]];
  end

  assign in_range      = {1'b0, ptr_r} < {image_kb_r, 10'd0};
  assign phase_inc     = (phase_r < 4'd15) ? phase_r + 4'd1 : phase_r;
  assign addr_need     = (cmd_r == CMD_SET_ADDR24) ? 2'd3 : 2'd2;
  assign pw_char       = (byte_r inside {[8'h41:8'h5A]}) ? byte_r + 8'h20 : byte_r;
  assign pw_miss       = pw_char != mem_q_r;
  assign erase_cnt_inc = erase_cnt_r + 16'd1;

  always_comb begin
    ptr_nxt       = ptr_r;
    cmd_nxt       = cmd_r;
    phase_nxt     = phase_r;
    enabled_nxt   = enabled_r;
    shift_nxt     = shift_r;
    lock_nxt      = lock_r;
    tries_nxt     = tries_r;
    dirty_nxt     = dirty_r;
    erase_cnt_nxt = erase_cnt_r;
    mismatch_nxt  = mismatch_r;
    tx_valid_nxt  = 1'b0;
    tx_byte_nxt   = 8'd0;
    store_wr      = 1'b0;
    case (req_r)
      REQ_CMD: begin
        cmd_nxt       = byte_r;
        phase_nxt     = 4'd0;
        shift_nxt     = 8'd0;
        erase_cnt_nxt = 16'd0;
        mismatch_nxt  = 1'b0;
        case (byte_r)
          CMD_RD_DEC_A, CMD_RD_DEC_B, CMD_RD_INC_A, CMD_RD_INC_B,
          CMD_WR_INC, CMD_WR_DEC: enabled_nxt = !lock_r;
          CMD_ERASE: enabled_nxt = (ptr_r == ERASE_START);
          CMD_STATUS, CMD_SET_ADDR16, CMD_SET_ADDR24,
          CMD_GET_ADDR16, CMD_GET_ADDR24: enabled_nxt = 1'b1;
          CMD_LOCK: begin
            lock_nxt    = 1'b1;
            enabled_nxt = 1'b0;
          end
          CMD_UNLOCK: enabled_nxt = lock_r && (tries_r < 2'(MAX_TRIES)) &&
                                    (ptr_r == 16'd0);
          default: enabled_nxt = 1'b0;
        endcase
      end
      REQ_DATA: begin
        if (enabled_r) begin
          case (cmd_r)
            CMD_WR_INC, CMD_WR_DEC: begin
              store_wr = in_range;
              if (in_range) dirty_nxt = 1'b1;
              ptr_nxt = (cmd_r == CMD_WR_DEC) ? ptr_r - 16'd1 : ptr_r + 16'd1;
            end
            CMD_ERASE: begin
              store_wr = in_range;
              if (in_range) dirty_nxt = 1'b1;
              ptr_nxt = ptr_r - 16'd1;
              if (lock_r) begin
                erase_cnt_nxt = erase_cnt_inc;
                // full 64 KB sweep while locked drops the lock
                if (erase_cnt_inc == 16'd0) begin
                  lock_nxt  = 1'b0;
                  tries_nxt = 2'd0;
                end
              end
            end
            CMD_SET_ADDR16, CMD_SET_ADDR24: begin
              if (phase_r < {2'b00, addr_need}) begin
                shift_nxt = byte_r;
                phase_nxt = phase_inc;
                if (phase_inc == {2'b00, addr_need}) ptr_nxt = {shift_r, byte_r};
              end
            end
            CMD_UNLOCK: begin
              if (phase_r < 4'(PASSWORD_LEN)) begin
                if (!mismatch_r) begin
                  mismatch_nxt = pw_miss;
                  ptr_nxt      = ptr_r + 16'd1;
                end
                phase_nxt = phase_inc;
                if (phase_inc == 4'(PASSWORD_LEN)) begin
                  if (mismatch_nxt) begin
                    if (tries_r != 2'd3) tries_nxt = tries_r + 2'd1;
                  end else begin
                    lock_nxt  = 1'b0;
                    tries_nxt = 2'd0;
                  end
                  enabled_nxt = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      REQ_SLOT: begin
        if (enabled_r) begin
          case (cmd_r)
            CMD_RD_DEC_A, CMD_RD_DEC_B, CMD_RD_INC_A, CMD_RD_INC_B: begin
              tx_valid_nxt = 1'b1;
              tx_byte_nxt  = mem_q_r;
              ptr_nxt = ((cmd_r & CMD_DIR_MASK) == 8'd0) ? ptr_r - 16'd1
                                                         : ptr_r + 16'd1;
            end
            CMD_STATUS: begin
              if (phase_r == 4'd0) begin
                tx_valid_nxt = 1'b1;
                tx_byte_nxt  = {lock_r, tries_r, 5'd0};
                phase_nxt    = phase_inc;
              end
            end
            CMD_GET_ADDR16: begin
              if (phase_r < 4'd2) begin
                tx_valid_nxt = 1'b1;
                tx_byte_nxt  = (phase_r == 4'd0) ? ptr_r[15:8] : ptr_r[7:0];
                phase_nxt    = phase_inc;
              end
            end
            CMD_GET_ADDR24: begin
              if (phase_r < 4'd3) begin
                tx_valid_nxt = 1'b1;
                // leading zero byte, then high and low pointer bytes
                tx_byte_nxt  = (phase_r == 4'd0) ? 8'd0 :
                               (phase_r == 4'd1) ? ptr_r[15:8] : ptr_r[7:0];
                phase_nxt    = phase_inc;
              end
            end
            default: ;
          endcase
        end
      end
      default: begin
        enabled_nxt = 1'b0;
        phase_nxt   = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= 16'd0;
      cmd_r       <= CMD_STATUS;
      phase_r     <= 4'd0;
      enabled_r   <= 1'b0;
      shift_r     <= 8'd0;
      lock_r      <= 1'b0;
      tries_r     <= 2'd0;
      dirty_r     <= 1'b0;
      erase_cnt_r <= 16'd0;
      mismatch_r  <= 1'b0;
    end else if (exec_done) begin
      ptr_r       <= ptr_nxt;
      cmd_r       <= cmd_nxt;
      phase_r     <= phase_nxt;
      enabled_r   <= enabled_nxt;
      shift_r     <= shift_nxt;
      lock_r      <= lock_nxt;
      tries_r     <= tries_nxt;
      dirty_r     <= dirty_nxt;
      erase_cnt_r <= erase_cnt_nxt;
      mismatch_r  <= mismatch_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      tx_valid_r  <= tx_valid_nxt;
      tx_byte_r   <= tx_byte_nxt;
      lock_out_r  <= lock_nxt;
      tries_out_r <= tries_nxt;
      dirty_out_r <= dirty_nxt;
      ptr_out_r   <= ptr_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = tx_valid_r;
  assign out_tdata    = {4'd0, ptr_out_r, dirty_out_r, tries_out_r, lock_out_r, tx_byte_r};

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("item accepted during clearing pass");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted item did not move to execute");

  a_store_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE))
    else $error("byte store written while idle");

  a_tx_only_on_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_done && tx_valid_nxt) |-> (req_r == REQ_SLOT))
    else $error("tx byte driven for a request that is not a read slot");

  a_unlock_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(lock_r)) |-> $past(state_r == S_EXEC))
    else $error("lock bit cleared outside execute");

endmodule
